// ===== rtl/core/mtc_pkg.sv =====
package mtc_pkg;

  localparam int unsigned Blocks = 8;
  localparam int unsigned Lags = 16;
  localparam int unsigned NumChan = Blocks * Lags;
  localparam int unsigned DlyDepth = Lags + 1;
  localparam int unsigned BlkW = (Blocks > 1) ? $clog2(Blocks) : 1;
  localparam int unsigned LagW = (Lags > 1) ? $clog2(Lags) : 1;
  localparam int unsigned TapW = $clog2(DlyDepth + 1);
  localparam int unsigned ChanW = $clog2(NumChan);
  localparam int unsigned DlyAddrW = $clog2(Blocks * DlyDepth);
  localparam int unsigned DlyW = 23;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] global_value;
    logic [15:0] local_value;
    logic [6:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [63:0] lag_sum;
    logic [12:0] lag_time;
    logic [31:0] block_ticks;
    logic [63:0] global_total;
  } out_item_t;

endpackage

// ===== rtl/core/mtc_stream_if.sv =====
interface mtc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mtc_ram.sv =====
module mtc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/multi_tau_correlator_unit.sv =====
// Multi-tau correlator with one shared multiply-accumulate unit.
// A push is accepted in the idle state; then each block that runs steps its taps
// from Lags+1 down to 0 through a fetch state and a MAC state, then a next-block state.
// A read state registers the result and offers it; input waits until it leaves.
// The step is set by the single read port of each state memory.
// After reset a clearing pass over Blocks*(Lags+1) addresses zeroes the memories
// while no transaction is accepted.
module multi_tau_correlator_unit (
  input logic clk,
  input logic rst_n,
  mtc_stream_if.sink   in_ch,
  mtc_stream_if.source out_ch
);

  typedef enum logic [6:0] {
    ST_CLR   = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_TAPRD = 7'b0001000,
    ST_TAP   = 7'b0010000,
    ST_MAC   = 7'b0100000,
    ST_NEXT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  localparam int unsigned ClrN = mtc_pkg::Blocks * mtc_pkg::DlyDepth;

  logic [mtc_pkg::DlyAddrW-1:0] clr_r;
  logic [mtc_pkg::BlkW-1:0]     blk_r;
  logic [mtc_pkg::TapW-1:0]     tap_r;
  logic signed [15:0]           g_r;
  logic [mtc_pkg::DlyW-1:0]     in_val_r;
  logic [mtc_pkg::DlyW-1:0]     carry_r;
  logic [63:0]                  gsum_r;
  logic [31:0]                  ticks_r [mtc_pkg::Blocks];
  logic [6:0]                   chan_r;
  logic                         out_valid_r;
  mtc_pkg::out_item_t           out_r;

  // Delay memory, one row of Lags+1 entries per block.
  logic                         d_we;
  logic [mtc_pkg::DlyAddrW-1:0] d_waddr, d_raddr;
  logic [mtc_pkg::DlyW-1:0]     d_wdata, d_rdata;

  mtc_ram #(.Width(mtc_pkg::DlyW), .Depth(ClrN)) u_dly (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // Lag accumulator memory.
  logic                        s_we;
  logic [mtc_pkg::ChanW-1:0]   s_waddr, s_raddr;
  logic [63:0]                 s_wdata, s_rdata;

  mtc_ram #(.Width(64), .Depth(mtc_pkg::NumChan)) u_sum (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic [mtc_pkg::DlyAddrW-1:0] row_base;
  logic [mtc_pkg::ChanW-1:0]    chan_idx;
  logic [mtc_pkg::DlyW-1:0]     tap_val;
  logic signed [mtc_pkg::DlyW+16:0] prod;
  logic [63:0]                  prod64;
  logic                         blk_even;
  logic                         last_blk;

  assign row_base = mtc_pkg::DlyAddrW'(32'(blk_r) * mtc_pkg::DlyDepth);
  assign chan_idx = mtc_pkg::ChanW'(32'(blk_r) * mtc_pkg::Lags + 32'(tap_r));
  assign tap_val  = (tap_r == '0) ? in_val_r : d_rdata;
  assign prod     = $signed({tap_val[mtc_pkg::DlyW-1], tap_val}) * g_r;
  assign prod64   = 64'(prod);
  assign blk_even = ~ticks_r[blk_r][0];
  assign last_blk = (32'(blk_r) == mtc_pkg::Blocks - 1);

  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Memory ports.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = row_base + mtc_pkg::DlyAddrW'(tap_r);
    d_wdata = '0;
    d_raddr = row_base + mtc_pkg::DlyAddrW'(tap_r);
    s_we    = 1'b0;
    s_waddr = chan_idx;
    s_wdata = s_rdata + prod64;
    s_raddr = chan_idx;
    case (state_r)
      ST_CLR: begin
        d_we    = 1'b1;
        d_waddr = clr_r;
        d_wdata = '0;
        s_we    = (32'(clr_r) < mtc_pkg::NumChan);
        s_waddr = mtc_pkg::ChanW'(clr_r);
        s_wdata = '0;
      end
      ST_IDLE: begin
        s_raddr = mtc_pkg::ChanW'(in_ch.data.channel);
      end
      ST_TAPRD: begin
        // Fetch delay entry tap-1 and the accumulator of this tap.
        d_raddr = row_base + mtc_pkg::DlyAddrW'(tap_r) - 1'b1;
      end
      ST_MAC: begin
        s_we = (32'(tap_r) < mtc_pkg::Lags);
        // Shift: entry tap-1 moves to entry tap; entry 0 takes the input.
        // The top tap lies past the row and only fetches the oldest entry.
        d_we    = (32'(tap_r) < mtc_pkg::DlyDepth);
        d_waddr = row_base + mtc_pkg::DlyAddrW'(tap_r);
        d_wdata = (tap_r == '0) ? in_val_r : d_rdata;
      end
      default: ;
    endcase
  end

  // Sequencer. Taps run from Lags+1 down to 0 so each entry is read
  // before its slot is overwritten.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (32'(clr_r) == ClrN - 1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          state_nxt = (in_ch.data.req_type == mtc_pkg::REQ_READ) ? ST_RD : ST_TAPRD;
        end
      end
      ST_RD:    state_nxt = ST_IDLE;
      ST_TAPRD: state_nxt = ST_MAC;
      ST_MAC:   state_nxt = (tap_r == '0) ? ST_NEXT : ST_TAPRD;
      ST_NEXT:  state_nxt = (blk_even && !last_blk) ? ST_TAPRD : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      gsum_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mtc_pkg::Blocks; i++) begin
        ticks_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            chan_r   <= in_ch.data.channel;
            g_r      <= $signed(in_ch.data.global_value);
            in_val_r <= mtc_pkg::DlyW'($signed(in_ch.data.local_value));
            blk_r    <= '0;
            tap_r    <= mtc_pkg::TapW'(mtc_pkg::DlyDepth);
            carry_r  <= '0;
            if (in_ch.data.req_type == mtc_pkg::REQ_PUSH) begin
              gsum_r <= gsum_r + 64'($signed(in_ch.data.global_value));
            end
          end
        end
        ST_RD: begin
          // Lag time is Lags*(2^b - 1) + k*2^b.
          out_valid_r <= 1'b1;
          out_r.global_total <= gsum_r;
          if (32'(chan_r) < mtc_pkg::NumChan) begin
            out_r.lag_sum     <= s_rdata;
            out_r.lag_time    <= 13'(((32'(mtc_pkg::Lags) + 32'(chan_r) % mtc_pkg::Lags)
                                  << (32'(chan_r) / mtc_pkg::Lags)) - mtc_pkg::Lags);
            out_r.block_ticks <= ticks_r[mtc_pkg::BlkW'(32'(chan_r) / mtc_pkg::Lags)];
          end else begin
            out_r.lag_sum     <= '0;
            out_r.lag_time    <= '0;
            out_r.block_ticks <= '0;
          end
        end
        ST_MAC: begin
          // The two oldest entries form the value passed on.
          if (32'(tap_r) >= mtc_pkg::Lags) begin
            carry_r <= carry_r + d_rdata;
          end
          tap_r <= tap_r - 1'b1;
        end
        ST_NEXT: begin
          ticks_r[blk_r] <= ticks_r[blk_r] + 1'b1;
          in_val_r <= carry_r;
          carry_r  <= '0;
          blk_r    <= blk_r + 1'b1;
          tap_r    <= mtc_pkg::TapW'(mtc_pkg::DlyDepth);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/mtc_correlator_checker.sv =====
// Watches both channels of the correlator, keeps its own copy of the
// correlator state and checks every read result against it.
module mtc_correlator_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  mtc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  mtc_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending
);

  // Mirrored correlator state.
  logic [63:0] tap_hist [mtc_pkg::Blocks][mtc_pkg::DlyDepth];
  logic [63:0] chan_sum [mtc_pkg::NumChan];
  logic [31:0] run_count [mtc_pkg::Blocks];
  logic [63:0] sample_total;

  // Read answers still owed by the block, oldest first.
  mtc_pkg::out_item_t answers_due[$];

  initial begin
    errors = 0;
    for (int b = 0; b < mtc_pkg::Blocks; b++) begin
      run_count[b] = '0;
      for (int k = 0; k < mtc_pkg::DlyDepth; k++) tap_hist[b][k] = '0;
    end
    for (int c = 0; c < mtc_pkg::NumChan; c++) chan_sum[c] = '0;
    sample_total = '0;
  end

  assign pending = answers_due.size();

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
    errors++;
  endtask

  // Runs block 0 and every block that the binning cascade reaches.
  task automatic apply_sample(input logic [15:0] gval, input logic [15:0] lval);
    logic [63:0] g;
    logic [63:0] feed;
    logic [63:0] carry;
    logic        was_even;
    g = {{48{gval[15]}}, gval};
    feed = {{48{lval[15]}}, lval};
    sample_total += g;
    for (int b = 0; b < mtc_pkg::Blocks; b++) begin
      for (int k = 0; k < mtc_pkg::Lags; k++)
        chan_sum[b * mtc_pkg::Lags + k] += g * ((k == 0) ? feed : tap_hist[b][k - 1]);
      carry = tap_hist[b][mtc_pkg::Lags - 1] + tap_hist[b][mtc_pkg::Lags];
      for (int k = mtc_pkg::Lags; k > 0; k--) tap_hist[b][k] = tap_hist[b][k - 1];
      tap_hist[b][0] = feed;
      was_even = ~run_count[b][0];
      run_count[b] += 1;
      if (!was_even) break;
      feed = carry;
    end
  endtask

  function automatic mtc_pkg::out_item_t answer_for(input logic [6:0] ch);
    mtc_pkg::out_item_t r;
    int unsigned b;
    int unsigned k;
    logic [63:0] t;
    r = '0;
    if (ch < mtc_pkg::NumChan) begin
      b = ch / mtc_pkg::Lags;
      k = ch % mtc_pkg::Lags;
      t = mtc_pkg::Lags * ((64'd1 << b) - 1) + k * (64'd1 << b);
      r.lag_sum = chan_sum[ch];
      r.lag_time = t[12:0];
      r.block_ticks = run_count[b];
    end
    r.global_total = sample_total;
    return r;
  endfunction

  // Accepted transactions on both channels.
  always @(posedge clk) begin
    mtc_pkg::out_item_t want;
    if (rst_n && in_valid && in_ready) begin
      if (in_data.req_type == mtc_pkg::REQ_PUSH)
        apply_sample(in_data.global_value, in_data.local_value);
      else
        answers_due.push_back(answer_for(in_data.channel));
    end
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $display("unexpected result transaction at %0t", $time);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (want.lag_sum !== out_data.lag_sum)
          report("lag_sum", want.lag_sum, out_data.lag_sum);
        if (want.lag_time !== out_data.lag_time)
          report("lag_time", want.lag_time, out_data.lag_time);
        if (want.block_ticks !== out_data.block_ticks)
          report("block_ticks", want.block_ticks, out_data.block_ticks);
        if (want.global_total !== out_data.global_total)
          report("global_total", want.global_total, out_data.global_total);
      end
    end
  end

endmodule

// ===== tb/tb_multi_tau_correlator_unit.sv =====
module tb_multi_tau_correlator_unit;

  localparam int WatchLimit = 5000;
  localparam int RandomItems = 700;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   results_seen;
  int   idle_cycles;

  mtc_stream_if #(.T(mtc_pkg::in_item_t))  in_ch ();
  mtc_stream_if #(.T(mtc_pkg::out_item_t)) out_ch ();

  multi_tau_correlator_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mtc_correlator_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Offers one transaction after a gap and holds it until accepted.
  task automatic offer(input mtc_pkg::in_item_t item, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic mtc_pkg::in_item_t sample_req(input logic [15:0] g, input logic [15:0] l);
    mtc_pkg::in_item_t it;
    it = '0;
    it.req_type = mtc_pkg::REQ_PUSH;
    it.global_value = g;
    it.local_value = l;
    it.channel = 7'($urandom);
    return it;
  endfunction

  function automatic mtc_pkg::in_item_t read_req(input logic [6:0] ch);
    mtc_pkg::in_item_t it;
    it.req_type = mtc_pkg::REQ_READ;
    it.global_value = 16'($urandom);
    it.local_value = 16'($urandom);
    it.channel = ch;
    return it;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus: reset, directed transactions, random mix, then drain.
  initial begin
    int gap;
    mtc_pkg::in_item_t it;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Extreme samples and reads at the corners of the lag array.
    offer(read_req(7'd0), 0);
    offer(sample_req(16'h7fff, 16'h7fff), 0);
    offer(sample_req(16'h8000, 16'h8000), 0);
    offer(sample_req(16'h8000, 16'h7fff), 1);
    offer(sample_req(16'h7fff, 16'h8000), 0);
    offer(sample_req(16'h0000, 16'h0000), 0);
    for (int i = 0; i < 6; i++) offer(sample_req(16'h8000, 16'h8000), 0);
    offer(read_req(7'd0), 0);
    offer(read_req(7'd15), 0);
    offer(read_req(7'd16), 2);
    offer(read_req(7'd17), 0);
    offer(read_req(7'd48), 0);
    offer(read_req(7'd112), 0);
    offer(read_req(7'd127), 0);

    for (int i = 0; i < RandomItems; i++) begin
      // Some stretches run back to back.
      gap = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 9) < 6)
        it = sample_req(pick_value(), pick_value());
      else
        it = read_req(7'($urandom_range(0, mtc_pkg::NumChan - 1)));
      offer(it, gap);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold-off so the block backs up.
  initial begin
    int gap;
    results_seen = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (results_seen == 12) gap = 400;
      else if ((results_seen / 30) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 12);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_seen++;
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("timeout waiting for a transaction");
      $display("FAIL");
      $finish;
    end
  end

endmodule
